@@ rtl/core/incremental_pid_controller_core_assert.svh @@
// Assertion helpers for the incremental PID controller core.
`ifndef INCREMENTAL_PID_CONTROLLER_CORE_ASSERT_SVH
`define INCREMENTAL_PID_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPID_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ipid assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ipid assertion failed");

`endif

@@ rtl/core/ipid_pkg.sv @@
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared widths, register indexes, reset values and payload types of the
// incremental PID controller core.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ErrW     = DataW + 1;  // target - measured
  localparam int unsigned DpW      = ErrW + 1;   // first difference
  localparam int unsigned DdW      = ErrW + 2;   // second difference
  localparam int unsigned ProdW    = GainW + 1 + DdW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain   = 3'd0,
    RegIntegGain  = 3'd1,
    RegDerivGain  = 3'd2,
    RegDriveUpper = 3'd3,
    RegDriveLower = 3'd4
  } ipid_reg_e;

  localparam logic [GainW-1:0]        PropGainRst   = 16'd2176;
  localparam logic [GainW-1:0]        IntegGainRst  = 16'd230;
  localparam logic [GainW-1:0]        DerivGainRst  = 16'd0;
  localparam logic signed [DataW-1:0] DriveUpperRst = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DriveLowerRst = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic [GainW-1:0]        prop_gain;
    logic [GainW-1:0]        integ_gain;
    logic [GainW-1:0]        deriv_gain;
    logic signed [DataW-1:0] drive_upper;
    logic signed [DataW-1:0] drive_lower;
  } ipid_cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] measured;
    logic signed [DataW-1:0] target;
    logic                    clear_history;
  } ipid_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    clipped;
  } ipid_out_t;

  typedef struct packed {
    logic                    clr;
    logic signed [ProdW-1:0] p_prop;
    logic signed [ProdW-1:0] p_integ;
    logic signed [ProdW-1:0] p_deriv;
  } ipid_prod_t;

endpackage

@@ rtl/core/ipid_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ipid_cfg_regs
// Gain and drive limit registers, written through a plain index/data port.
// ----------------------------------------------------------------------------
module ipid_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipid_pkg::CfgDataW-1:0]  cfg_data_i,
  output ipid_pkg::ipid_cfg_t            cfg_o
);
  import ipid_pkg::*;

  ipid_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ipid_reg_e'(cfg_idx_i))
        RegPropGain:   cfg_d.prop_gain   = cfg_data_i[GainW-1:0];
        RegIntegGain:  cfg_d.integ_gain  = cfg_data_i[GainW-1:0];
        RegDerivGain:  cfg_d.deriv_gain  = cfg_data_i[GainW-1:0];
        RegDriveUpper: cfg_d.drive_upper = cfg_data_i[DataW-1:0];
        RegDriveLower: cfg_d.drive_lower = cfg_data_i[DataW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PropGainRst;
      cfg_q.integ_gain  <= IntegGainRst;
      cfg_q.deriv_gain  <= DerivGainRst;
      cfg_q.drive_upper <= DriveUpperRst;
      cfg_q.drive_lower <= DriveLowerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/incremental_pid_controller_core.sv @@
// An accepted transaction moves through the input, product and output registers in turn.
// Throughput: one transaction per cycle while no finished result is stalled; the error
// history updates in the multiply stage and the drive accumulator in the clamp stage.
// The whole pipeline holds only while a finished result waits under stall.
// Reset clears the history, the accumulator and all valid bits, and loads the
// gains and limits with their default values.
// ----------------------------------------------------------------------------
// incremental_pid_controller_core
// Velocity-form PID: the error and its differences times gains are added to a
// fixed-point drive accumulator, which is clamped to the configured limits or cleared.
// ----------------------------------------------------------------------------
module incremental_pid_controller_core #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipid_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ipid_pkg::ipid_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ipid_pkg::ipid_out_t            out_data_o
);
  import ipid_pkg::*;

  localparam int unsigned AccW = DataW + GAIN_FRAC_BITS;

  ipid_cfg_t cfg;

  ipid_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                   adv;
  logic                   s1_valid_q, s2_valid_q, out_valid_q;
  ipid_in_t               s1_data_q;
  ipid_prod_t             s2_prod_q, s2_prod_d;
  ipid_out_t              out_data_q, out_data_d;
  logic signed [ErrW-1:0] err1_q, err2_q, err_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  // advance everything unless a finished result is stalled
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---- multiply stage ----
  logic signed [DpW-1:0] dp;
  logic signed [DdW-1:0] dd;

  always_comb begin
    err_d = ErrW'(s1_data_q.target) - ErrW'(s1_data_q.measured);
    dp    = DpW'(err_d) - DpW'(err1_q);
    dd    = DdW'(err_d) - (DdW'(err1_q) <<< 1) + DdW'(err2_q);
    s2_prod_d.clr     = s1_data_q.clear_history;
    s2_prod_d.p_prop  = ProdW'($signed({1'b0, cfg.prop_gain}))  * ProdW'(dp);
    s2_prod_d.p_integ = ProdW'($signed({1'b0, cfg.integ_gain})) * ProdW'(err_d);
    s2_prod_d.p_deriv = ProdW'($signed({1'b0, cfg.deriv_gain})) * ProdW'(dd);
  end

  // ---- accumulate and clamp stage ----
  logic signed [SumW-1:0] sum, upper_full, lower_full;

  always_comb begin
    sum = SumW'(s2_prod_q.p_prop) + SumW'(s2_prod_q.p_integ)
        + SumW'(s2_prod_q.p_deriv) + SumW'(acc_q);
    upper_full = SumW'(cfg.drive_upper) <<< GAIN_FRAC_BITS;
    lower_full = SumW'(cfg.drive_lower) <<< GAIN_FRAC_BITS;
    out_data_d.clipped = 1'b0;
    if (s2_prod_q.clr) begin
      acc_d = '0;
    end else if (sum > upper_full) begin
      acc_d = AccW'(upper_full);
      out_data_d.clipped = 1'b1;
    end else if (sum < lower_full) begin
      acc_d = AccW'(lower_full);
      out_data_d.clipped = 1'b1;
    end else begin
      acc_d = AccW'(sum);
    end
    // integer part, rounded toward minus infinity
    out_data_d.drive = acc_d[GAIN_FRAC_BITS +: DataW];
  end

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      err1_q      <= '0;
      err2_q      <= '0;
      acc_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s1_valid_q) begin
        if (s1_data_q.clear_history) begin
          err1_q <= '0;
          err2_q <= '0;
        end else begin
          err1_q <= err_d;
          err2_q <= err1_q;
        end
      end
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_data_q  <= in_data_i;
      s2_prod_q  <= s2_prod_d;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/ipid_checker.sv @@
// ----------------------------------------------------------------------------
// ipid_checker
// Port-level checks of the incremental PID controller core, bound to the top.
// ----------------------------------------------------------------------------
`include "incremental_pid_controller_core_assert.svh"

module ipid_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [ipid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [ipid_pkg::CfgDataW-1:0]  cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input ipid_pkg::ipid_out_t            out_data_o
);
  import ipid_pkg::*;

  logic signed [DataW-1:0] upper_q, lower_q;
  logic [1:0]              inflight_q;
  logic                    in_take, out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // shadow the drive limits from the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= DriveUpperRst;
      lower_q <= DriveLowerRst;
    end else if (cfg_we_i) begin
      if (ipid_reg_e'(cfg_idx_i) == RegDriveUpper) begin
        upper_q <= cfg_data_i[DataW-1:0];
      end
      if (ipid_reg_e'(cfg_idx_i) == RegDriveLower) begin
        lower_q <= cfg_data_i[DataW-1:0];
      end
    end
  end

  // transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_take && !out_take) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_take && !in_take) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  `IPID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `IPID_ASSERT_IMPL(a_clip_at_limit, clk_i, rst_ni, out_valid_o && out_data_o.clipped, out_data_o.drive == upper_q || out_data_o.drive == lower_q)

  // a clear transaction reports zero whatever the limits are
  `IPID_ASSERT_IMPL(a_unclipped_range, clk_i, rst_ni, out_valid_o && !out_data_o.clipped, (out_data_o.drive >= lower_q && out_data_o.drive <= upper_q) || out_data_o.drive == '0)

  `IPID_ASSERT_IMPL(a_no_spurious_out, clk_i, rst_ni, out_valid_o, inflight_q != 2'd0)

endmodule

bind incremental_pid_controller_core ipid_checker u_ipid_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for incremental_pid_controller_core. It drives measurement
// and setpoint transactions, predicts the saturated drive in fixed point, and
// compares every result in order. Gains and limits are rewritten between phases,
// including zero and full-scale gains and full-scale, equal and inverted limits.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipid_pkg::*;

  localparam int FracBits   = 8;
  localparam int PhaseItems = 84;
  localparam int LongHold   = 300;
  localparam int QuietLimit = 3000;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd5;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ipid_in_t            in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ipid_out_t           out_data;

  // Controller state as the bench sees it.
  int     kp = int'(PropGainRst);
  int     ki = int'(IntegGainRst);
  int     kd = int'(DerivGainRst);
  int     lim_hi = int'(DriveUpperRst);
  int     lim_lo = int'(DriveLowerRst);
  longint err_last;
  longint err_older;
  longint drive_accum;

  ipid_in_t  step_q[$];
  ipid_out_t drive_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int err_cnt;
  int setpoint;
  int quiet_cycles;

  incremental_pid_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic log_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Advance the velocity-form loop by one transaction and return its drive.
  function automatic ipid_out_t drive_model_step(ipid_in_t it);
    longint err, d1, d2, top, bottom, whole;
    ipid_out_t res;
    res = '0;
    if (it.clear_history) begin
      err_last    = 0;
      err_older   = 0;
      drive_accum = 0;
      return res;
    end
    err = longint'($signed(it.target)) - longint'($signed(it.measured));
    d1  = err - err_last;
    d2  = err - 2 * err_last + err_older;
    drive_accum += longint'(kp) * d1 + longint'(ki) * err + longint'(kd) * d2;
    top    = longint'(lim_hi) * (longint'(1) << FracBits);
    bottom = longint'(lim_lo) * (longint'(1) << FracBits);
    // Upper limit wins when the limits are inverted.
    if (drive_accum > top) begin
      drive_accum = top;
      res.clipped = 1'b1;
    end else if (drive_accum < bottom) begin
      drive_accum = bottom;
      res.clipped = 1'b1;
    end
    err_older = err_last;
    err_last  = err;
    whole = drive_accum >>> FracBits;
    res.drive = whole[DataW-1:0];
    return res;
  endfunction

  function automatic ipid_in_t make_step(int meas, int targ, bit clr);
    ipid_in_t it;
    it.measured      = meas[DataW-1:0];
    it.target        = targ[DataW-1:0];
    it.clear_history = clr;
    return it;
  endfunction

  // Mostly a loop tracking a slowly moving setpoint, with raw noise and clears.
  function automatic ipid_in_t random_step();
    ipid_in_t it;
    int pick;
    it = '0;
    pick = $urandom_range(99);
    if (pick < 4) begin
      it.clear_history = 1'b1;
      it.measured      = 16'($urandom);
      it.target        = 16'($urandom);
    end else if (pick < 24) begin
      it.measured = 16'($urandom);
      it.target   = 16'($urandom);
    end else begin
      if ($urandom_range(15) == 0) setpoint = $urandom_range(0, 8000) - 4000;
      it.target   = setpoint[DataW-1:0];
      it.measured = 16'(setpoint + $urandom_range(0, 64) - 32);
    end
    return it;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegPropGain:   kp = int'(val);
      RegIntegGain:  ki = int'(val);
      RegDerivGain:  kd = int'(val);
      RegDriveUpper: lim_hi = int'($signed(val));
      RegDriveLower: lim_lo = int'($signed(val));
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                               logic [15:0] hi, logic [15:0] lo);
    write_reg(RegPropGain, p);
    write_reg(RegIntegGain, i);
    write_reg(RegDerivGain, d);
    write_reg(RegDriveUpper, hi);
    write_reg(RegDriveLower, lo);
    // Unmapped index: must leave every register alone.
    write_reg(RegFirstUnused + 3'($urandom_range(0, 2)), 16'($urandom));
  endtask

  // Hold until every queued transaction has gone through and its result is back.
  task automatic drain();
    while (step_q.size() != 0 || in_valid || drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: offer the next transaction once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) drive_expect_q.push_back(drive_model_step(in_data));
      if (step_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= step_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker.
  int hold_left;
  int hold_served;
  always @(posedge clk_i) begin : monitor
    ipid_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          log_error("result with nothing expected");
        end else begin
          want = drive_expect_q.pop_front();
          if (out_data.drive !== want.drive)
            log_error($sformatf("drive got %0d want %0d", out_data.drive, want.drive));
          if (out_data.clipped !== want.clipped)
            log_error($sformatf("clipped got %0b want %0b", out_data.clipped, want.clipped));
        end
      end
      if (hold_served != hold_reqs) begin
        hold_left   = LongHold;
        hold_served = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Reset gains: extremes of the error, saturation both ways, floor of negatives.
    step_q.push_back(make_step(0, 0, 1'b0));
    step_q.push_back(make_step(-32768, 32767, 1'b0));
    step_q.push_back(make_step(-32768, 32767, 1'b0));
    step_q.push_back(make_step(32767, -32768, 1'b0));
    step_q.push_back(make_step(32767, -32768, 1'b1));
    step_q.push_back(make_step(100, 101, 1'b0));
    step_q.push_back(make_step(101, 100, 1'b0));
    step_q.push_back(make_step(0, -1, 1'b0));
    step_q.push_back(make_step(-1, -1, 1'b1));
    drain();

    // Integral and derivative only, inverted limits.
    apply_setting(16'd0, 16'd1, 16'hFFFF, 16'hFFFB, 16'd5);
    step_q.push_back(make_step(0, 1, 1'b0));
    step_q.push_back(make_step(0, -1, 1'b0));
    step_q.push_back(make_step(0, 3, 1'b0));
    step_q.push_back(make_step(0, 0, 1'b1));
    drain();

    // Derivative only, wide limits: second difference at full swing.
    apply_setting(16'd0, 16'd0, 16'd1, 16'h7FFF, 16'h8000);
    step_q.push_back(make_step(32767, -32768, 1'b0));
    step_q.push_back(make_step(-32768, 32767, 1'b0));
    step_q.push_back(make_step(32767, -32768, 1'b0));
    step_q.push_back(make_step(0, 0, 1'b0));
    step_q.push_back(make_step(5, 3, 1'b0));
    step_q.push_back(make_step(0, 0, 1'b1));
    drain();

    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin send_idle_pct = 33; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (s)
        0: apply_setting(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
                         16'($urandom_range(0, 511)), 16'h7FFF, 16'h8000);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000, -16'sd1000);
        2: apply_setting(16'd0, 16'd0, 16'd0, 16'($urandom_range(0, 32767)),
                         16'($urandom_range(0, 32768) * -1));
        3: apply_setting(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
                         16'($urandom_range(0, 511)), -16'sd300, 16'd300);
        4: apply_setting(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
                         16'($urandom_range(0, 511)), 16'd77, 16'd77);
        default: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom));
      endcase
      setpoint = $urandom_range(0, 8000) - 4000;
      for (int n = 0; n < PhaseItems; n++) step_q.push_back(random_step());
      // Back-pressure: block the output while transactions keep coming.
      if (s == 1) hold_reqs++;
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
